>>> rtl/mjs_pkg.sv
// Package for the 3x3 majority smoothing block.
// Holds the shared constants, register indexes and the structs passed between modules.
// No dependencies.
package mjs_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int HEIGHT_LIMIT   = 4096;
    localparam int ROW_W          = 12;
    localparam int DIM_W          = 13;
    localparam int TERRAIN_W      = 4;
    localparam int TERRAIN_IDS    = 12;
    localparam int STAY_THRESHOLD = 4;
    localparam int JOIN_THRESHOLD = 6;
    localparam int CNT_W          = 4;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET  = 3'd0,
        REG_OUTSIDE = 3'd1,
        REG_WIDTH   = 3'd2,
        REG_HEIGHT  = 3'd3,
        REG_WATER   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [TERRAIN_W-1:0]   target_terrain;
        logic [TERRAIN_W-1:0]   outside_terrain;
        logic [DIM_W-1:0]       grid_width;
        logic [DIM_W-1:0]       grid_height;
        logic [TERRAIN_IDS-1:0] water_tile_mask;
    } t_cfg;

    // One cell waiting for its decision.
    typedef struct packed {
        logic [CNT_W-1:0]     cnt;
        logic [TERRAIN_W-1:0] terrain;
        logic                 last;
    } t_cell;

    typedef struct packed {
        logic  a_valid;
        logic  b_valid;
        t_cell a;
        t_cell b;
    } t_push;

    typedef struct packed {
        logic  valid;
        t_cell entry;
    } t_head;

    function automatic logic [CNT_W-1:0] bits3(input logic [2:0] v);
        return CNT_W'(v[0]) + CNT_W'(v[1]) + CNT_W'(v[2]);
    endfunction

endpackage

>>> rtl/mjs_in_if.sv
// Input channel of the smoothing block: one column slice per transfer.
// No dependencies.
interface mjs_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] upper_terrain;
    logic [3:0] middle_terrain;
    logic [3:0] lower_terrain;

    modport source (output valid, output upper_terrain, output middle_terrain,
                    output lower_terrain, input ready);
    modport sink (input valid, input upper_terrain, input middle_terrain,
                  input lower_terrain, output ready);
endinterface

>>> rtl/mjs_out_if.sv
// Output channel of the smoothing block: one decided cell per transfer.
// No dependencies.
interface mjs_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] new_terrain;
    logic       changed;
    logic       water_flag;
    logic       prop_cleared;
    logic       end_of_run;

    modport source (output valid, output new_terrain, output changed, output water_flag,
                    output prop_cleared, output end_of_run, input ready);
    modport sink (input valid, input new_terrain, input changed, input water_flag,
                  input prop_cleared, input end_of_run, output ready);
endinterface

>>> rtl/mjs_front.sv
// Front end: accepts column slices, tracks position and window, and pushes cells to decide.
// Depends on mjs_pkg and mjs_in_if.
module mjs_front import mjs_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_room,
    mjs_in_if.sink i_cell,
    output t_push o_push
);
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WX    = (COL_W > DIM_W) ? COL_W + 1 : DIM_W + 1;

    logic [5:0]           r_win, n_win;
    logic [TERRAIN_W-1:0] r_held;
    logic [COL_W-1:0]     r_col, n_col;
    logic [ROW_W-1:0]     r_row, n_row;

    logic [WX-1:0]    gw_ext, w_lim;
    logic [DIM_W-1:0] h_lim;
    logic             top, bottom, last, first, acc;
    logic [2:0]       cur, older;

    assign acc          = i_cell.valid && i_room;
    assign i_cell.ready = i_room;

    always_comb begin
        gw_ext = WX'(i_cfg.grid_width);
        if (i_cfg.grid_width == '0) begin
            w_lim = WX'(1);
        end else if (gw_ext > WX'(MAX_WIDTH)) begin
            w_lim = WX'(MAX_WIDTH);
        end else begin
            w_lim = gw_ext;
        end
        if (i_cfg.grid_height == '0) begin
            h_lim = DIM_W'(1);
        end else if (i_cfg.grid_height > DIM_W'(HEIGHT_LIMIT)) begin
            h_lim = DIM_W'(HEIGHT_LIMIT);
        end else begin
            h_lim = i_cfg.grid_height;
        end
        top    = (r_row == '0);
        bottom = (DIM_W'(r_row) >= h_lim - DIM_W'(1));
        last   = (WX'(r_col) >= w_lim - WX'(1));
        first  = (r_col == '0);

        cur[0] = !top && (i_cell.upper_terrain == i_cfg.target_terrain);
        cur[1] = (i_cell.middle_terrain == i_cfg.target_terrain);
        cur[2] = !bottom && (i_cell.lower_terrain == i_cfg.target_terrain);
        older  = first ? 3'b000 : r_win[5:3];

        o_push.a_valid      = acc && !first;
        o_push.b_valid      = acc && last;
        o_push.a.cnt        = bits3(r_win[2:0]) + bits3(cur)
                              + CNT_W'(r_win[3]) + CNT_W'(r_win[5]);
        o_push.a.terrain    = r_held;
        o_push.a.last       = !last;
        o_push.b.cnt        = bits3(older) + CNT_W'(cur[0]) + CNT_W'(cur[2]);
        o_push.b.terrain    = i_cell.middle_terrain;
        o_push.b.last       = 1'b1;

        if (last) begin
            n_win = 6'b0;
            n_col = '0;
            n_row = bottom ? '0 : r_row + ROW_W'(1);
        end else begin
            n_win = {cur, older};
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_held <= '0;
            r_col  <= '0;
            r_row  <= '0;
        end else if (acc) begin
            r_win  <= n_win;
            r_held <= i_cell.middle_terrain;
            r_col  <= n_col;
            r_row  <= n_row;
        end
    end
endmodule

>>> rtl/mjs_queue.sv
// Short queue between front and back: takes up to two cells a cycle and releases one when popped.
// Depends on mjs_pkg.
module mjs_queue import mjs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output t_head o_head,
    output logic  o_room
);
    t_cell             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_push;
    logic              pop_ok;

    assign pop_ok      = i_pop && (r_cnt != '0);
    assign n_push      = QCNT_W'(i_push.a_valid) + QCNT_W'(i_push.b_valid);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.entry = r_mem[r_rp];
    assign o_room      = (r_cnt <= QCNT_W'(QUEUE_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wp] <= i_push.a;
            if (i_push.b_valid) begin
                r_mem[r_wp + QPTR_W'(1)] <= i_push.b;
            end
        end else if (i_push.b_valid) begin
            r_mem[r_wp] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + QPTR_W'(n_push);
            r_rp  <= r_rp + QPTR_W'(pop_ok);
            r_cnt <= r_cnt + n_push - QCNT_W'(pop_ok);
        end
    end
endmodule

>>> rtl/mjs_back.sv
// Back end: applies the majority rule to queued cells and holds each result for transfer.
// Depends on mjs_pkg and mjs_out_if.
module mjs_back import mjs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  t_head i_head,
    output logic  o_pop,
    mjs_out_if.source o_cell
);
    logic                 r_valid;
    logic [TERRAIN_W-1:0] r_terrain;
    logic                 r_changed, r_water, r_prop, r_last;

    logic                 is_in, stay, chg, water;
    logic [TERRAIN_W-1:0] nt;

    assign o_pop = i_head.valid && (!r_valid || o_cell.ready);

    always_comb begin
        is_in = (i_head.entry.terrain == i_cfg.target_terrain);
        stay  = is_in ? (i_head.entry.cnt >= CNT_W'(STAY_THRESHOLD))
                      : (i_head.entry.cnt >= CNT_W'(JOIN_THRESHOLD));
        chg   = (stay != is_in);
        nt    = i_head.entry.terrain;
        water = 1'b0;
        if (chg) begin
            nt = stay ? i_cfg.target_terrain : i_cfg.outside_terrain;
            if (nt < TERRAIN_W'(TERRAIN_IDS)) begin
                water = i_cfg.water_tile_mask[nt];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_cell.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_terrain <= nt;
            r_changed <= chg;
            r_water   <= water;
            r_prop    <= chg && stay;
            r_last    <= i_head.entry.last;
        end
    end

    assign o_cell.valid        = r_valid;
    assign o_cell.new_terrain  = r_terrain;
    assign o_cell.changed      = r_changed;
    assign o_cell.water_flag   = r_water;
    assign o_cell.prop_cleared = r_prop;
    assign o_cell.end_of_run   = r_last;
endmodule

>>> rtl/majority_smoothing_3x3.sv
// Top level of the 3x3 majority smoothing block: configuration registers and the three stages.
// Depends on mjs_pkg, mjs_in_if, mjs_out_if, mjs_front, mjs_queue and mjs_back.
//
// The block takes one column slice per cycle while the queue has room (a cell with the cells
// above and below it) and returns each decided cell one column later; the last slice of a row
// returns two cells and the first none, so a row of W slices yields W results. The output stage
// delivers one result per cycle while the sink is ready; a four-entry queue between the
// classifying front end and the deciding back end absorbs the extra end-of-row result and output
// stalls, holding off input when under two entries are free. The user must write configuration
// only while no slice is in flight; the block does not enforce this.
module majority_smoothing_3x3 import mjs_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mjs_in_if.sink                i_cell,
    mjs_out_if.source             o_cell
);
    t_cfg  r_cfg;
    t_push push;
    t_head head;
    logic  room, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_terrain  <= '0;
            r_cfg.outside_terrain <= '0;
            r_cfg.grid_width      <= DIM_W'(1);
            r_cfg.grid_height     <= DIM_W'(1);
            r_cfg.water_tile_mask <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_TARGET:  r_cfg.target_terrain  <= i_cfg_data[TERRAIN_W-1:0];
                REG_OUTSIDE: r_cfg.outside_terrain <= i_cfg_data[TERRAIN_W-1:0];
                REG_WIDTH:   r_cfg.grid_width      <= i_cfg_data[DIM_W-1:0];
                REG_HEIGHT:  r_cfg.grid_height     <= i_cfg_data[DIM_W-1:0];
                REG_WATER:   r_cfg.water_tile_mask <= i_cfg_data[TERRAIN_IDS-1:0];
                default: begin
                end
            endcase
        end
    end

    mjs_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_room (room),
        .i_cell (i_cell),
        .o_push (push)
    );

    mjs_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_pop  (pop),
        .o_head (head),
        .o_room (room)
    );

    mjs_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_head (head),
        .o_pop  (pop),
        .o_cell (o_cell)
    );
endmodule
